@@ src/time_window_min_max_history_core_assert.svh @@
// Assertion macros used by the checker of the time window min/max history core.
`ifndef TIME_WINDOW_MIN_MAX_HISTORY_CORE_ASSERT_SVH
`define TIME_WINDOW_MIN_MAX_HISTORY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWMMH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twmmh assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWMMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twmmh assertion failed");

`endif

@@ src/twmmh_pkg.sv @@
// Package with the types and codes of the time window min/max history core.
package twmmh_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned VAL_W  = 32;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_MIN = 2'd1;
  localparam logic [1:0] ACT_MAX = 2'd2;

  typedef struct packed {
    logic        [TIME_W-1:0] stamp;
    logic signed [VAL_W-1:0]  value;
  } twmmh_entry_t;

  localparam int unsigned ENTRY_W = $bits(twmmh_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_SCAN,
    ST_DONE
  } twmmh_state_e;

endpackage

@@ src/twmmh_in_if.sv @@
// Input channel interface carrying one add or query word.
interface twmmh_in_if;
  import twmmh_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [TIME_W-1:0]        time_stamp;
  logic [TIME_W-1:0]        window_start;
  logic signed [VAL_W-1:0]  sample;
  logic                     sample_valid;

  modport source (
    output valid, action, time_stamp, window_start, sample, sample_valid,
    input  ready
  );

  modport sink (
    input  valid, action, time_stamp, window_start, sample, sample_valid,
    output ready
  );
endinterface

@@ src/twmmh_out_if.sv @@
// Output channel interface carrying one query result word.
interface twmmh_out_if;
  import twmmh_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  extreme_value;
  logic                     extreme_defined;

  modport source (
    output valid, extreme_value, extreme_defined,
    input  ready
  );

  modport sink (
    input  valid, extreme_value, extreme_defined,
    output ready
  );
endinterface

@@ src/twmmh_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module twmmh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/time_window_min_max_history_core.sv @@
// An add writes the sample, then evicts expired entries, one per cycle from the oldest slot.
// A query scans back from the newest entry until it meets one older than window_start or the last one.
// At most DEPTH entries are scanned, as the one RAM read port reads them in turn.
// A query whose current value is invalid skips the scan and gives its result from ST_DONE.
// Reset is asynchronous and active low; it empties the ring and clears the period.
// The RAM contents are not reset and need no clearing pass.
module time_window_min_max_history_core #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [twmmh_pkg::TIME_W-1:0] cfg_wdata_i,
  twmmh_in_if.sink                  in_i,
  twmmh_out_if.source               out_o
);
  import twmmh_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);

  twmmh_state_e            state_q, state_d;
  logic [IW-1:0]           oldest_q, oldest_d;
  logic [CW-1:0]           count_q, count_d;
  logic [TIME_W-1:0]       period_q, period_d;
  logic [TIME_W-1:0]       bound_q, bound_d;
  logic [TIME_W-1:0]       start_q, start_d;
  logic signed [VAL_W-1:0] best_q, best_d;
  logic                    is_min_q, is_min_d;
  logic                    defined_q, defined_d;
  logic [IW-1:0]           slot_q, slot_d;
  logic [CW-1:0]           left_q, left_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  logic                    out_defined_q, out_defined_d;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  twmmh_entry_t            ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;
  twmmh_entry_t            rd_entry;

  logic [IW:0]             tail_sum;
  logic [IW-1:0]           tail_slot;
  logic [IW-1:0]           newest_slot;
  logic [IW-1:0]           oldest_next;
  logic [IW-1:0]           slot_prev;
  logic                    better;

  twmmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = twmmh_entry_t'(ram_rdata);

  always_comb begin
    tail_sum    = {1'b0, oldest_q} + (IW + 1)'(count_q);
    tail_slot   = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : tail_sum[IW-1:0];
    newest_slot = (tail_slot == '0) ? LAST_IDX : tail_slot - 1'b1;
    oldest_next = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
    slot_prev   = (slot_q == '0) ? LAST_IDX : slot_q - 1'b1;
    better      = is_min_q ? (rd_entry.value < best_q) : (rd_entry.value > best_q);
  end

  always_comb begin
    state_d       = state_q;
    oldest_d      = oldest_q;
    count_d       = count_q;
    period_d      = cfg_we_i ? cfg_wdata_i : period_q;
    bound_d       = bound_q;
    start_d       = start_q;
    best_d        = best_q;
    is_min_d      = is_min_q;
    defined_d     = defined_q;
    slot_d        = slot_q;
    left_d        = left_q;
    out_valid_d   = out_valid_q;
    out_value_d   = out_value_q;
    out_defined_d = out_defined_q;
    ram_we        = 1'b0;
    ram_waddr     = tail_slot;
    ram_wdata     = '{stamp: in_i.time_stamp, value: in_i.sample};
    ram_raddr     = oldest_q;
    in_i.ready    = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          case (in_i.action) inside
            ACT_ADD: begin
              if (in_i.sample_valid && (period_q != '0)) begin
                ram_we = 1'b1;
                if (count_q == FULL_CNT) begin
                  ram_waddr = oldest_q;
                  oldest_d  = oldest_next;
                end else begin
                  count_d = count_q + 1'b1;
                end
                bound_d = (in_i.time_stamp > period_q) ? in_i.time_stamp - period_q : '0;
                state_d = ST_EV_RD;
              end
            end
            ACT_MIN, ACT_MAX: begin
              is_min_d = (in_i.action == ACT_MIN);
              start_d  = in_i.window_start;
              if (!in_i.sample_valid) begin
                best_d    = '0;
                defined_d = 1'b0;
                state_d   = ST_DONE;
              end else begin
                best_d    = in_i.sample;
                defined_d = 1'b1;
                if (count_q == '0) begin
                  state_d = ST_DONE;
                end else begin
                  ram_raddr = newest_slot;
                  slot_d    = newest_slot;
                  left_d    = count_q;
                  state_d   = ST_SCAN;
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EV_RD: begin
        state_d = ST_EV_CHK;
      end
      ST_EV_CHK: begin
        if ((count_q != '0) && (rd_entry.stamp < bound_q)) begin
          oldest_d  = oldest_next;
          count_d   = count_q - 1'b1;
          ram_raddr = oldest_next;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (rd_entry.stamp < start_q) begin
          state_d = ST_DONE;
        end else begin
          if (better) begin
            best_d = rd_entry.value;
          end
          if (left_q == CW'(1)) begin
            state_d = ST_DONE;
          end else begin
            left_d    = left_q - 1'b1;
            slot_d    = slot_prev;
            ram_raddr = slot_prev;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_value_d   = best_q;
          out_defined_d = defined_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q       <= bound_d;
    start_q       <= start_d;
    best_q        <= best_d;
    is_min_q      <= is_min_d;
    defined_q     <= defined_d;
    slot_q        <= slot_d;
    left_q        <= left_d;
    out_value_q   <= out_value_d;
    out_defined_q <= out_defined_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.extreme_value   = out_value_q;
  assign out_o.extreme_defined = out_defined_q;

endmodule

@@ src/twmmh_checker.sv @@
// Port-level assertion checker for the time window min/max history core, with its bind.
`include "time_window_min_max_history_core_assert.svh"

module twmmh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [1:0]                    in_action_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [twmmh_pkg::VAL_W-1:0]   out_value_i,
  input logic                          out_defined_i
);
  import twmmh_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `TWMMH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
    out_valid_i && $stable(out_value_i) && $stable(out_defined_i))
  `TWMMH_ASSERT_SAME(a_undef_zero, clk_i, rst_ni, out_valid_i && !out_defined_i,
    out_value_i == '0)
  `TWMMH_ASSERT_NEXT(a_query_busy, clk_i, rst_ni,
    in_acc && (in_action_i == ACT_MIN || in_action_i == ACT_MAX), !in_ready_i)
  `TWMMH_ASSERT_NEXT(a_add_silent, clk_i, rst_ni, in_acc && in_action_i == ACT_ADD,
    !$rose(out_valid_i))

endmodule

bind time_window_min_max_history_core twmmh_checker u_twmmh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_value_i   (out_o.extreme_value),
  .out_defined_i (out_o.extreme_defined)
);
